>>> sv/two_pkg.sv
// Package: shared types, constants and arc tangent table for tracking wheel odometry.
`timescale 1ns / 1ps
`default_nettype none
package two_pkg;

   // Request word: wheel positions, sensor heading, zero request
   typedef struct packed {
      logic signed [31:0] vertical_count;
      logic signed [31:0] horizontal_count;
      logic signed [31:0] heading_raw;
      logic               zero_heading;
   } req_type;

   // Response word: pose
   typedef struct packed {
      logic signed [39:0] pos_x;
      logic signed [39:0] pos_y;
      logic signed [31:0] heading;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE,
      S_QUAD,
      S_ZINIT,
      S_CORDIC,
      S_MUL,
      S_ACC,
      S_ROUND,
      S_COMMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       red_step;
      logic       quad;
      logic       zinit;
      logic       rot_step;
      logic       mul;
      logic       acc;
      logic       round;
      logic       commit;
      logic [4:0] idx;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_busy;
   } sts_type;

   localparam logic [15:0] DPC_RESET  = 16'd2928;
   localparam logic [33:0] MOD_FULL   = 34'd72000;
   localparam logic [34:0] RED_BIAS   = 35'd4320000000;
   localparam logic [4:0]  RED_TOP    = 5'd17;
   localparam logic [16:0] QUAD_1     = 17'd18000;
   localparam logic [16:0] QUAD_2     = 17'd36000;
   localparam logic [16:0] QUAD_3     = 17'd54000;
   localparam logic [1:0]  TERM_LAST  = 2'd3;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

   localparam int TBL_N = 32;
   typedef logic [TBL_N-1:0][63:0] atan_tbl_type;

   // Unsigned quotient by shift and subtract, for tables built at elaboration
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rmd;
      int b;
      quo = '0;
      rmd = '0;
      for (b = 63; b >= 0; b--) begin
         rmd = {rmd[62:0], num[b]};
         if (rmd >= den) begin
            rmd = rmd - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // pi/4 in Q60 by Machin's formula
   function automatic longint quarter_pi();
      longint p;
      longint t;
      longint s5;
      longint s239;
      int k;
      p = 64'sd1 <<< 60;
      p = p / 5;
      s5 = 0;
      k = 0;
      while (p != 0) begin
         t = longint'(udiv64(64'(p), 64'(2 * k + 1)));
         s5 = (k % 2 == 1) ? s5 - t : s5 + t;
         p = p / 25;
         k++;
      end
      p = 64'sd1 <<< 60;
      p = p / 239;
      s239 = 0;
      k = 0;
      while (p != 0) begin
         t = longint'(udiv64(64'(p), 64'(2 * k + 1)));
         s239 = (k % 2 == 1) ? s239 - t : s239 + t;
         p = p / 57121;
         k++;
      end
      return 4 * s5 - s239;
   endfunction

   // atan(2^-i) in Q60 by the alternating series
   function automatic atan_tbl_type build_atan();
      atan_tbl_type tbl;
      longint sum;
      longint t;
      int i;
      int k;
      int e;
      tbl[0] = quarter_pi();
      for (i = 1; i < TBL_N; i++) begin
         sum = 0;
         k = 0;
         e = 60 - i;
         while (e >= 0) begin
            t = longint'(udiv64(64'd1 << e, 64'(2 * k + 1)));
            sum = (k % 2 == 1) ? sum - t : sum + t;
            k++;
            e = 60 - i * (2 * k + 1);
         end
         tbl[i] = sum;
      end
      return tbl;
   endfunction

   localparam atan_tbl_type ATAN_TBL = build_atan();
   localparam logic [63:0] UNIT_Q60 = 64'((4 * quarter_pi()) / 36000);

endpackage
`default_nettype wire

>>> sv/tracking_wheel_odometry.sv
// Top level: two tracking wheel dead-reckoning odometry.
//
// One request word per tick gives both wheel positions and the sensor heading; one
// response word gives x, y (saturating, 1/1024 inch) and the heading after offset.
// After a word is accepted it passes through binary angle reduction, quadrant split
// and angle scaling, CORDIC_STEPS rotation steps of the shared CORDIC unit, four
// products on the shared multiplier pair, then rounding and the commit. The commit
// waits while the response register still holds an unaccepted word. The next word
// is taken the cycle after the commit, so one word is processed at a time. The
// response register holds a finished word while the next one is processed. The user
// must write the scale register over the csr port only while the block is idle; the
// block itself does not enforce it, and csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module tracking_wheel_odometry #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire two_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output two_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [15:0]      csr_data
);
   two_pkg::cmd_type cmd;
   two_pkg::sts_type sts;

   // Accept scale writes every cycle
   assign csr_ready = 1'b1;

   two_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   two_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> sv/two_ctrl.sv
// Controller: sequences load, angle reduction, CORDIC, products, rounding and commit.
`timescale 1ns / 1ps
`default_nettype none
module two_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire two_pkg::sts_type sts,
   output two_pkg::cmd_type   cmd
);
   localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

   two_pkg::state_type state_ff;
   two_pkg::state_type state_in;
   logic [4:0]         cnt_ff;
   logic [4:0]         cnt_in;

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         two_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = two_pkg::S_REDUCE;
               cnt_in   = two_pkg::RED_TOP;
            end
         end
         two_pkg::S_REDUCE: begin
            if (cnt_ff == 5'd0) begin
               state_in = two_pkg::S_QUAD;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         two_pkg::S_QUAD: begin
            state_in = two_pkg::S_ZINIT;
            cnt_in   = 5'd0;
         end
         two_pkg::S_ZINIT: begin
            state_in = two_pkg::S_CORDIC;
            cnt_in   = 5'd0;
         end
         two_pkg::S_CORDIC: begin
            if (cnt_ff == LAST_STEP) begin
               state_in = two_pkg::S_MUL;
               cnt_in   = 5'd0;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         two_pkg::S_MUL: begin
            state_in = two_pkg::S_ACC;
         end
         two_pkg::S_ACC: begin
            if (cnt_ff[1:0] == two_pkg::TERM_LAST) begin
               state_in = two_pkg::S_ROUND;
            end else begin
               state_in = two_pkg::S_MUL;
               cnt_in   = cnt_ff + 5'd1;
            end
         end
         two_pkg::S_ROUND: begin
            state_in = two_pkg::S_COMMIT;
         end
         two_pkg::S_COMMIT: begin
            if (!sts.out_busy) begin
               state_in = two_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = two_pkg::S_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd          = '0;
      cmd.idx      = cnt_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         two_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         two_pkg::S_REDUCE: cmd.red_step = 1'b1;
         two_pkg::S_QUAD:   cmd.quad     = 1'b1;
         two_pkg::S_ZINIT:  cmd.zinit    = 1'b1;
         two_pkg::S_CORDIC: cmd.rot_step = 1'b1;
         two_pkg::S_MUL:    cmd.mul      = 1'b1;
         two_pkg::S_ACC:    cmd.acc      = 1'b1;
         two_pkg::S_ROUND:  cmd.round    = 1'b1;
         two_pkg::S_COMMIT: cmd.commit   = !sts.out_busy;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= two_pkg::S_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/two_dp.sv
// Datapath: pose state, angle reduction, CORDIC, distance products and output register.
`timescale 1ns / 1ps
`default_nettype none
module two_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire two_pkg::cmd_type cmd,
   output two_pkg::sts_type      sts,
   input  wire two_pkg::req_type req_data,
   input  wire logic             csr_valid,
   input  wire logic [15:0]      csr_data,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output two_pkg::rsp_type      rsp_data
);
   // Persistent state
   logic        [15:0] dpc_ff;
   logic signed [31:0] off_ff, off_in;
   logic signed [31:0] last_v_ff;
   logic signed [31:0] last_h_ff;
   logic signed [31:0] last_hd_ff;
   logic               first_ff;
   logic signed [39:0] x_acc_ff, x_acc_in;
   logic signed [39:0] y_acc_ff, y_acc_in;

   // Working registers
   logic signed [31:0] hd_ff, hd_in;
   logic signed [32:0] dv_ff, dv_in;
   logic signed [32:0] dh_ff, dh_in;
   logic signed [48:0] dist_v_ff, dist_v_in;
   logic signed [48:0] dist_h_ff, dist_h_in;
   logic        [33:0] red_ff, red_in;
   logic        [1:0]  q_ff, q_in;
   logic        [14:0] r2_ff, r2_in;
   logic signed [63:0] z_ff, z_in;
   logic signed [33:0] cx_ff, cx_in;
   logic signed [33:0] cy_ff, cy_in;
   logic        [56:0] p_hi_ff, p_hi_in;
   logic        [56:0] p_lo_ff, p_lo_in;
   logic               neg_ff, neg_in;
   logic signed [57:0] dx_ff, dx_in;
   logic signed [57:0] dy_ff, dy_in;
   logic signed [38:0] dxr_ff, dxr_in;
   logic signed [38:0] dyr_ff, dyr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   two_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // Load: offset, heading, mid-step angle and wheel deltas
   logic signed [31:0] lh_sel;
   logic        [34:0] mid_sum;
   always_comb begin
      off_in = req_data.zero_heading ? req_data.heading_raw : off_ff;
      hd_in  = req_data.heading_raw - off_in;
      if (first_ff) begin
         lh_sel = hd_in;
      end else if (req_data.zero_heading) begin
         lh_sel = '0;
      end else begin
         lh_sel = last_hd_ff;
      end
      mid_sum = {{3{lh_sel[31]}}, lh_sel} + {{3{hd_in[31]}}, hd_in} + two_pkg::RED_BIAS;
      dv_in = {req_data.vertical_count[31], req_data.vertical_count}
            - {last_v_ff[31], last_v_ff};
      dh_in = {req_data.horizontal_count[31], req_data.horizontal_count}
            - {last_h_ff[31], last_h_ff};
   end

   // Reduce the biased angle modulo one turn, one binary step a cycle; scale wheel deltas
   logic        [33:0] red_sub;
   logic signed [49:0] prod_v;
   logic signed [49:0] prod_h;
   always_comb begin
      red_sub = two_pkg::MOD_FULL << cmd.idx;
      if (cmd.load) begin
         red_in = mid_sum[33:0];
      end else if (red_ff >= red_sub) begin
         red_in = red_ff - red_sub;
      end else begin
         red_in = red_ff;
      end
      prod_v    = 50'(dv_ff) * $signed({1'b0, dpc_ff});
      prod_h    = 50'(dh_ff) * $signed({1'b0, dpc_ff});
      dist_v_in = prod_v[48:0];
      dist_h_in = prod_h[48:0];
   end

   // Split the turn into quadrant and remainder
   logic [16:0] rem;
   always_comb begin
      rem = red_ff[16:0];
      priority if (rem >= two_pkg::QUAD_3) begin
         q_in  = 2'd3;
         r2_in = 15'(rem - two_pkg::QUAD_3);
      end else if (rem >= two_pkg::QUAD_2) begin
         q_in  = 2'd2;
         r2_in = 15'(rem - two_pkg::QUAD_2);
      end else if (rem >= two_pkg::QUAD_1) begin
         q_in  = 2'd1;
         r2_in = 15'(rem - two_pkg::QUAD_1);
      end else begin
         q_in  = 2'd0;
         r2_in = 15'(rem);
      end
   end

   // CORDIC rotation: init or one step
   logic signed [33:0] sh_x;
   logic signed [33:0] sh_y;
   logic signed [63:0] at;
   always_comb begin
      sh_x = cx_ff >>> cmd.idx;
      sh_y = cy_ff >>> cmd.idx;
      at   = $signed(two_pkg::ATAN_TBL[cmd.idx]);
      if (cmd.zinit) begin
         z_in  = $signed(64'(r2_ff) * two_pkg::UNIT_Q60);
         cx_in = two_pkg::GAIN_Q30;
         cy_in = '0;
      end else if (!z_ff[63]) begin
         z_in  = z_ff - at;
         cx_in = cx_ff - sh_y;
         cy_in = cy_ff + sh_x;
      end else begin
         z_in  = z_ff + at;
         cx_in = cx_ff + sh_y;
         cy_in = cy_ff - sh_x;
      end
   end

   // Apply quadrant, pick term operands, split product
   logic signed [33:0] cos_v;
   logic signed [33:0] sin_v;
   logic signed [48:0] dist_sel;
   logic signed [33:0] trig_sel;
   logic        [48:0] dist_abs;
   logic        [33:0] trig_abs;
   always_comb begin
      unique case (q_ff)
         2'd0: begin cos_v = cx_ff;  sin_v = cy_ff;  end
         2'd1: begin cos_v = -cy_ff; sin_v = cx_ff;  end
         2'd2: begin cos_v = -cx_ff; sin_v = -cy_ff; end
         default: begin cos_v = cy_ff; sin_v = -cx_ff; end
      endcase
      unique case (cmd.idx[1:0])
         2'd0: begin dist_sel = dist_h_ff; trig_sel = cos_v; end
         2'd1: begin dist_sel = dist_v_ff; trig_sel = sin_v; end
         2'd2: begin dist_sel = dist_v_ff; trig_sel = cos_v; end
         default: begin dist_sel = dist_h_ff; trig_sel = sin_v; end
      endcase
      dist_abs = dist_sel[48] ? 49'(-dist_sel) : 49'(dist_sel);
      trig_abs = trig_sel[33] ? 34'(-trig_sel) : 34'(trig_sel);
      p_hi_in  = 57'(dist_abs[47:24]) * 57'(trig_abs[32:0]);
      p_lo_in  = 57'(dist_abs[23:0]) * 57'(trig_abs[32:0]);
      neg_in   = dist_sel[48] ^ trig_sel[33];
   end

   // Sum the two partial products, truncate toward zero, accumulate
   logic        [56:0] mag;
   logic signed [57:0] term;
   always_comb begin
      mag  = p_hi_ff + (p_lo_ff >> 24);
      term = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      dx_in = dx_ff;
      dy_in = dy_ff;
      unique case (cmd.idx[1:0])
         2'd0: dx_in = term;
         2'd1: dx_in = dx_ff + term;
         2'd2: dy_in = term;
         default: dy_in = dy_ff - term;
      endcase
   end

   // Round to 1/1024 inch, half away from zero
   logic [57:0] adx;
   logic [57:0] ady;
   logic [37:0] rx;
   logic [37:0] ry;
   always_comb begin
      adx    = dx_ff[57] ? 58'(-dx_ff) : 58'(dx_ff);
      ady    = dy_ff[57] ? 58'(-dy_ff) : 58'(dy_ff);
      rx     = 38'((adx + 58'd524288) >> 20);
      ry     = 38'((ady + 58'd524288) >> 20);
      dxr_in = dx_ff[57] ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
      dyr_in = dy_ff[57] ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
   end

   // Saturating accumulate and result word
   logic signed [40:0] sum_x;
   logic signed [40:0] sum_y;
   always_comb begin
      sum_x = {x_acc_ff[39], x_acc_ff} + {{2{dxr_ff[38]}}, dxr_ff};
      sum_y = {y_acc_ff[39], y_acc_ff} + {{2{dyr_ff[38]}}, dyr_ff};
      if (sum_x[40] != sum_x[39]) begin
         x_acc_in = sum_x[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         x_acc_in = sum_x[39:0];
      end
      if (sum_y[40] != sum_y[39]) begin
         y_acc_in = sum_y[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         y_acc_in = sum_y[39:0];
      end
      rsp_data_in.pos_x   = x_acc_in;
      rsp_data_in.pos_y   = y_acc_in;
      rsp_data_in.heading = hd_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff       <= two_pkg::DPC_RESET;
         off_ff       <= '0;
         last_v_ff    <= '0;
         last_h_ff    <= '0;
         last_hd_ff   <= '0;
         first_ff     <= 1'b1;
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            dpc_ff <= csr_data;
         end
         if (cmd.load) begin
            off_ff     <= off_in;
            last_v_ff  <= req_data.vertical_count;
            last_h_ff  <= req_data.horizontal_count;
            last_hd_ff <= hd_in;
            first_ff   <= 1'b0;
         end
         if (cmd.commit) begin
            x_acc_ff <= x_acc_in;
            y_acc_ff <= y_acc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hd_ff <= hd_in;
         dv_ff <= dv_in;
         dh_ff <= dh_in;
      end
      if (cmd.load || cmd.red_step) begin
         red_ff <= red_in;
      end
      if (cmd.red_step) begin
         dist_v_ff <= dist_v_in;
         dist_h_ff <= dist_h_in;
      end
      if (cmd.quad) begin
         q_ff  <= q_in;
         r2_ff <= r2_in;
      end
      if (cmd.zinit || cmd.rot_step) begin
         z_ff  <= z_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
      if (cmd.mul) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         neg_ff  <= neg_in;
      end
      if (cmd.acc) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.round) begin
         dxr_ff <= dxr_in;
         dyr_ff <= dyr_in;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule
`default_nettype wire

>>> test/tracking_wheel_odometry_checker.sv
// Checker: watches the request, response and csr channels, predicts the pose and compares it.
`timescale 1ns / 1ps
`default_nettype none
module tracking_wheel_odometry_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire two_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire two_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [15:0]      csr_data,
   output int                    pending,
   output int                    fail_count,
   output int                    poses_checked
);
   localparam int  ROT_STEPS = 16;
   localparam longint POS_MAX = 64'sd549755813887;
   localparam longint POS_MIN = -64'sd549755813888;

   // Arc tangent table and angle unit in Q60
   longint arc_q60 [32];
   longint angle_unit;

   // Pose and history
   logic [15:0]        scale;
   logic signed [31:0] prev_v;
   logic signed [31:0] prev_h;
   logic signed [31:0] prev_hdg;
   logic signed [31:0] hdg_offset;
   longint             x_pos;
   longint             y_pos;
   logic               first;

   two_pkg::rsp_type pose_q [$];

   // atan(1/den) in Q60, alternating series
   function automatic longint atan_recip(input logic [63:0] den);
      logic [63:0] p;
      longint sum;
      longint t;
      logic [63:0] k;
      p = (64'd1 << 60) / den;
      sum = 0;
      k = 0;
      while (p != 0) begin
         t = longint'(p / (2 * k + 1));
         sum = k[0] ? sum - t : sum + t;
         p = p / (den * den);
         k++;
      end
      return sum;
   endfunction

   initial begin
      longint qp;
      longint sum;
      int e;
      int k;
      qp = 4 * atan_recip(64'd5) - atan_recip(64'd239);
      arc_q60[0] = qp;
      for (int i = 1; i < 32; i++) begin
         sum = 0;
         k = 0;
         e = 60 - i;
         while (e >= 0) begin
            sum = (k % 2 == 1) ? sum - longint'((64'd1 << e) / (2 * k + 1))
                               : sum + longint'((64'd1 << e) / (2 * k + 1));
            k++;
            e = 60 - i * (2 * k + 1);
         end
         arc_q60[i] = sum;
      end
      angle_unit = (4 * qp) / 36000;
   end

   // cos and sin in Q30 of an angle in 1/200 degree
   function automatic void rotate(input longint m, output longint c, output longint s);
      longint r;
      longint q;
      longint x;
      longint y;
      longint z;
      longint ddx;
      longint ddy;
      r = m % 72000;
      if (r < 0) r += 72000;
      q = r / 18000;
      r = r % 18000;
      z = r * angle_unit;
      x = 652032874;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         ddx = y >>> i;
         ddy = x >>> i;
         if (z >= 0) begin
            x -= ddx; y += ddy; z -= arc_q60[i];
         end else begin
            x += ddx; y -= ddy; z += arc_q60[i];
         end
      end
      case (q)
         0: begin c = x;  s = y;  end
         1: begin c = -y; s = x;  end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // distance (2^-24 inch) times Q30 trig, in 2^-30 inch, truncated toward zero
   function automatic longint scaled_mul(input longint travel, input longint trig);
      logic [63:0] a;
      logic [63:0] t;
      logic [63:0] mag;
      a = travel < 0 ? -travel : travel;
      t = trig < 0 ? -trig : trig;
      mag = (a >> 24) * t + (({40'd0, a[23:0]} * t) >> 24);
      return ((travel < 0) != (trig < 0)) ? -longint'(mag) : longint'(mag);
   endfunction

   // 2^-30 inch to 1/1024 inch, half away from zero
   function automatic longint round_out(input longint v);
      logic [63:0] a;
      longint r;
      a = v < 0 ? -v : v;
      r = longint'((a + (64'd1 << 19)) >> 20);
      return v < 0 ? -r : r;
   endfunction

   function automatic longint clamp40(input longint v);
      return v > POS_MAX ? POS_MAX : (v < POS_MIN ? POS_MIN : v);
   endfunction

   // Advance the pose by one tick and return the expected response word
   function automatic two_pkg::rsp_type advance_pose(input two_pkg::req_type w);
      logic signed [31:0] hd;
      longint c;
      longint s;
      longint dv;
      longint dh;
      two_pkg::rsp_type o;
      if (w.zero_heading) begin
         hdg_offset = w.heading_raw;
         prev_hdg = 0;
      end
      hd = w.heading_raw - hdg_offset;
      if (first) prev_hdg = hd;
      rotate(longint'(prev_hdg) + longint'(hd), c, s);
      dv = (longint'(w.vertical_count) - longint'(prev_v)) * longint'(scale);
      dh = (longint'(w.horizontal_count) - longint'(prev_h)) * longint'(scale);
      x_pos = clamp40(x_pos + round_out(scaled_mul(dh, c) + scaled_mul(dv, s)));
      y_pos = clamp40(y_pos + round_out(scaled_mul(dv, c) - scaled_mul(dh, s)));
      prev_v = w.vertical_count;
      prev_h = w.horizontal_count;
      prev_hdg = hd;
      first = 1'b0;
      o.pos_x = x_pos[39:0];
      o.pos_y = y_pos[39:0];
      o.heading = hd;
      return o;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
      poses_checked = 0;
   end

   // Compare responses first, then take config and new ticks
   always @(posedge clock) begin
      two_pkg::rsp_type want;
      if (reset) begin
         scale = two_pkg::DPC_RESET;
         prev_v = 0;
         prev_h = 0;
         prev_hdg = 0;
         hdg_offset = 0;
         x_pos = 0;
         y_pos = 0;
         first = 1'b1;
         pose_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pose_q.size() == 0) begin
               $display("%0t: unexpected response word %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = pose_q.pop_front();
               poses_checked++;
               if (rsp_data.pos_x !== want.pos_x) begin
                  $display("%0t: pos_x expected %0d got %0d", $time,
                           want.pos_x, rsp_data.pos_x);
                  fail_count++;
               end
               if (rsp_data.pos_y !== want.pos_y) begin
                  $display("%0t: pos_y expected %0d got %0d", $time,
                           want.pos_y, rsp_data.pos_y);
                  fail_count++;
               end
               if (rsp_data.heading !== want.heading) begin
                  $display("%0t: heading expected %0d got %0d", $time,
                           want.heading, rsp_data.heading);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) scale = csr_data;
         if (req_valid && req_ready) pose_q.push_back(advance_pose(req_data));
      end
      pending = pose_q.size();
   end

endmodule
`default_nettype wire

>>> test/tracking_wheel_odometry_tb.sv
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tracking_wheel_odometry_tb;
   localparam int PHASE_TICKS = 140;
   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 400;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   two_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   two_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [15:0]      csr_data;

   int pending;
   int fail_count;
   int poses_checked;
   int idle_cycles;
   int ticks_sent;
   int zero_sent;
   int csr_writes;
   logic hold_off;
   logic burst;

   logic signed [31:0] cur_v;
   logic signed [31:0] cur_h;
   logic signed [31:0] cur_hdg;

   tracking_wheel_odometry dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   tracking_wheel_odometry_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .pending(pending), .fail_count(fail_count), .poses_checked(poses_checked)
   );

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   // Watchdog: count cycles with no word moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one tick and hold it until accepted
   task automatic push_tick(input two_pkg::req_type w);
      @(negedge clock);
      req_valid = 1'b1;
      req_data = w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
      if (w.zero_heading) zero_sent++;
   endtask

   // Drop valid for a random gap, mostly short, sometimes long
   task automatic sender_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (burst || r < 65) return;
      n = (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 120);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Wait for the block to drain, then write the scale register
   task automatic write_scale(input logic [15:0] val);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   function automatic two_pkg::req_type make_tick(input logic signed [31:0] v,
                                                  input logic signed [31:0] h,
                                                  input logic signed [31:0] hdg,
                                                  input logic zero);
      two_pkg::req_type w;
      w.vertical_count = v;
      w.horizontal_count = h;
      w.heading_raw = hdg;
      w.zero_heading = zero;
      return w;
   endfunction

   // Random walk with occasional full-range jumps and heading re-zero
   function automatic two_pkg::req_type random_tick();
      if ($urandom_range(0, 99) < 85) cur_v = cur_v + $signed($urandom_range(0, 4000)) - 2000;
      else cur_v = $urandom;
      if ($urandom_range(0, 99) < 85) cur_h = cur_h + $signed($urandom_range(0, 4000)) - 2000;
      else cur_h = $urandom;
      if ($urandom_range(0, 99) < 88) cur_hdg = cur_hdg + $signed($urandom_range(0, 6000)) - 3000;
      else cur_hdg = $urandom;
      return make_tick(cur_v, cur_h, cur_hdg, $urandom_range(0, 99) < 4);
   endfunction

   // Full-swing forward/backward strokes with heading flips drive y into a rail
   task automatic drive_to_rail(input logic toward_max, input int count);
      logic signed [31:0] top;
      logic signed [31:0] bot;
      logic signed [31:0] base;
      top = toward_max ? 32'sh7FFFFFFF : 32'sh80000000;
      bot = toward_max ? 32'sh80000000 : 32'sh7FFFFFFF;
      base = $urandom;
      push_tick(make_tick(bot, cur_h, base, 1'b1));
      for (int k = 0; k < count; k++) begin
         case (k % 4)
            0: push_tick(make_tick(top, cur_h, base, 1'b0));
            1: push_tick(make_tick(top, cur_h, base + 18000, 1'b0));
            2: push_tick(make_tick(bot, cur_h, base + 18000, 1'b0));
            default: push_tick(make_tick(bot, cur_h, base, 1'b0));
         endcase
      end
      cur_v = bot;
      cur_hdg = base;
   endtask

   // Receiver: random stalls, quiet stretches, and one long hold-off on request
   initial begin
      int r;
      rsp_ready = 1'b0;
      hold_off = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else if (burst) begin
            rsp_ready = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            rsp_ready = (r >= 30);
            if (r < 3) begin
               rsp_ready = 1'b0;
               repeat ($urandom_range(20, 100)) @(negedge clock);
            end
         end
      end
   end

   initial begin
      logic [15:0] phase_scale [5];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      idle_cycles = 0;
      ticks_sent = 0;
      zero_sent = 0;
      csr_writes = 0;
      burst = 1'b0;
      cur_v = 0;
      cur_h = 0;
      cur_hdg = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: first tick with a heading, field extremes, re-zero and wraps
      push_tick(make_tick(1000, -500, 4500, 1'b0));
      push_tick(make_tick(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0));
      push_tick(make_tick(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b0));
      push_tick(make_tick(0, 0, 32'sh80000000, 1'b1));
      push_tick(make_tick(100, 100, 32'sh7FFFFFFF, 1'b0));
      push_tick(make_tick(200, 300, 9000, 1'b1));
      push_tick(make_tick(5000, 300, 18000, 1'b0));
      push_tick(make_tick(5000, 8000, 27000, 1'b0));
      push_tick(make_tick(-7000, 8000, 36000, 1'b0));
      push_tick(make_tick(-7000, -9000, -36000, 1'b0));
      push_tick(make_tick(0, 0, 72000, 1'b0));
      push_tick(make_tick(-1, -1, -1, 1'b0));
      write_scale(16'd0);
      push_tick(make_tick(32'sh7FFFFFFF, 32'sh80000000, 123, 1'b0));
      write_scale(16'hFFFF);
      push_tick(make_tick(32'sh80000000, 32'sh7FFFFFFF, -4567, 1'b0));
      push_tick(make_tick(12345, -54321, 98765, 1'b1));
      cur_v = 12345;
      cur_h = -54321;
      cur_hdg = 98765;

      // Random phases over several scale settings; the widest scale hits both rails
      phase_scale[0] = 16'd1;
      phase_scale[1] = 16'hFFFF;
      phase_scale[2] = $urandom_range(1, 65535);
      phase_scale[3] = 16'd0;
      phase_scale[4] = two_pkg::DPC_RESET;
      for (int p = 0; p < 5; p++) begin
         write_scale(phase_scale[p]);
         if (p == 1) begin
            drive_to_rail(1'b1, 80);
            drive_to_rail(1'b0, 150);
         end
         for (int i = 0; i < PHASE_TICKS; i++) begin
            if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            if (p == 2 && i == 40) hold_off = 1'b1;
            sender_gap();
            push_tick(random_tick());
         end
      end
      @(negedge clock);
      req_valid = 1'b0;
      burst = 1'b0;

      // Drain and let the block settle
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);

      $display("Ran %0d ticks (%0d with heading re-zero), %0d scale writes,",
               ticks_sent, zero_sent, csr_writes);
      $display("%0d poses checked, including both saturation rails.", poses_checked);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
